@@ hw/rtl/s2dc_pkg.sv @@
// shared types, constants and the bcd adjust-and-shift helper for the
// signed-to-decimal converter; no dependencies
`timescale 1ns / 1ps

package s2dc_pkg;

    localparam int VALUE_W       = 64;
    localparam int DIGITS        = 20;
    localparam int DIGIT_W       = 4;
    localparam int BCD_W         = DIGITS * DIGIT_W;
    localparam int CHAR_W        = 8;
    localparam int CNT_W         = 5;
    localparam int BITS_PER_STEP = 4;
    localparam int STEPS         = VALUE_W / BITS_PER_STEP;
    localparam int STEP_W        = $clog2(STEPS);
    localparam int FIFO_DEPTH    = 2;
    localparam int PTR_W         = $clog2(FIFO_DEPTH);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

    // job handed from the front to the converter
    typedef struct packed {
        logic               neg;
        logic [VALUE_W-1:0] mag;
    } job_t;

    // finished conversion waiting for the emitter
    typedef struct packed {
        logic             valid;
        logic             neg;
        logic [BCD_W-1:0] bcd;
    } conv_res_t;

    typedef enum logic [1:0] {
        CONV_IDLE,
        CONV_SHIFT,
        CONV_DONE
    } conv_state_t;

    // one double-dabble step: add 3 to every digit >= 5, then shift one bit in
    function automatic logic [BCD_W-1:0] dabble_bit(input logic [BCD_W-1:0] bcd,
                                                    input logic bit_in);
        logic [BCD_W-1:0] adj;
        adj = bcd;
        for (int d = 0; d < DIGITS; d++) begin
            if (adj[d*DIGIT_W +: DIGIT_W] >= 4'd5) begin
                adj[d*DIGIT_W +: DIGIT_W] = adj[d*DIGIT_W +: DIGIT_W] + 4'd3;
            end
        end
        return {adj[BCD_W-2:0], bit_in};
    endfunction

endpackage

@@ hw/rtl/signed_to_decimal_chars.sv @@
// signed 64-bit integer to decimal ascii text, one character per word
// input queue port: push/full; output queue port: empty/pop
// a negative value gives a leading '-', leading zeros are dropped, zero gives "0"
// each output word carries char_code, chars_so_far (1..20) and is_last
// a word is taken on push && !full and a character leaves on pop && !empty
// the front end forms sign and magnitude and queues up to two jobs; the
// converter runs shift-and-add-3 at four bits per cycle
// after a load step and a minus for a negative value, the emitter steps
// through all 20 digit slots one per cycle, a printed digit waiting until the
// output register can take it while a dropped leading zero never waits
// the converter works on the next value while the emitter prints this one
// into an idle block the first character comes after the queue, the conversion
// and the emitter's load, later the more leading zeros a non-negative value has
// a stalled receiver freezes the emitter at its output register; the
// converter and queue then fill and full rises
// reset empties the queue and all stages; no value is carried across reset
// depends on s2dc_pkg, s2dc_front, s2dc_fifo, s2dc_conv, s2dc_emit
`timescale 1ns / 1ps

module signed_to_decimal_chars (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic signed [s2dc_pkg::VALUE_W-1:0] value,
    output logic                                empty,
    input  logic                                pop,
    output logic [s2dc_pkg::CHAR_W-1:0]         char_code,
    output logic [s2dc_pkg::CNT_W-1:0]          chars_so_far,
    output logic                                is_last
);

    logic                 fifo_full;
    logic                 fifo_empty;
    logic                 fifo_wr;
    logic                 fifo_rd;
    s2dc_pkg::job_t       fifo_wr_data;
    s2dc_pkg::job_t       fifo_rd_data;
    s2dc_pkg::conv_res_t  conv_res;
    logic                 take;

    s2dc_front u_front (
        .push         (push),
        .full         (full),
        .value        (value),
        .fifo_full    (fifo_full),
        .fifo_wr      (fifo_wr),
        .fifo_wr_data (fifo_wr_data)
    );

    s2dc_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (fifo_wr),
        .wr_data (fifo_wr_data),
        .full    (fifo_full),
        .rd      (fifo_rd),
        .rd_data (fifo_rd_data),
        .empty   (fifo_empty)
    );

    s2dc_conv u_conv (
        .clk          (clk),
        .rst_n        (rst_n),
        .fifo_empty   (fifo_empty),
        .fifo_rd_data (fifo_rd_data),
        .fifo_rd      (fifo_rd),
        .take         (take),
        .res          (conv_res)
    );

    s2dc_emit u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .res          (conv_res),
        .take         (take),
        .empty        (empty),
        .pop          (pop),
        .char_code    (char_code),
        .chars_so_far (chars_so_far),
        .is_last      (is_last)
    );

endmodule

@@ hw/rtl/s2dc_front.sv @@
// front end: takes input words, splits off the sign and forms the magnitude
// depends on s2dc_pkg
`timescale 1ns / 1ps

module s2dc_front (
    input  logic                                push,
    output logic                                full,
    input  logic signed [s2dc_pkg::VALUE_W-1:0] value,
    input  logic                                fifo_full,
    output logic                                fifo_wr,
    output s2dc_pkg::job_t                      fifo_wr_data
);

    logic [s2dc_pkg::VALUE_W-1:0] raw;

    assign raw  = $unsigned(value);
    assign full = fifo_full;

    assign fifo_wr          = push && !fifo_full;
    assign fifo_wr_data.neg = raw[s2dc_pkg::VALUE_W-1];
    // most negative value negates to itself, which is the right magnitude unsigned
    assign fifo_wr_data.mag = raw[s2dc_pkg::VALUE_W-1] ? (~raw + 1'b1) : raw;

endmodule

@@ hw/rtl/s2dc_fifo.sv @@
// short job queue between the front end and the converter
// depends on s2dc_pkg
`timescale 1ns / 1ps

module s2dc_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr,
    input  s2dc_pkg::job_t wr_data,
    output logic           full,
    input  logic           rd,
    output s2dc_pkg::job_t rd_data,
    output logic           empty
);

    s2dc_pkg::job_t                 mem [s2dc_pkg::FIFO_DEPTH];
    logic [s2dc_pkg::PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [s2dc_pkg::PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [s2dc_pkg::PTR_W:0]       count_reg, count_next;

    assign full    = count_reg == (s2dc_pkg::PTR_W+1)'(s2dc_pkg::FIFO_DEPTH);
    assign empty   = count_reg == '0;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr)
        begin
            wr_ptr_next = (wr_ptr_reg == s2dc_pkg::PTR_W'(s2dc_pkg::FIFO_DEPTH-1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (rd)
        begin
            rd_ptr_next = (rd_ptr_reg == s2dc_pkg::PTR_W'(s2dc_pkg::FIFO_DEPTH-1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (wr && !rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd && !wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ hw/rtl/s2dc_conv.sv @@
// binary to bcd converter, shift-and-add-3, four bits per cycle
// depends on s2dc_pkg
`timescale 1ns / 1ps

module s2dc_conv (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fifo_empty,
    input  s2dc_pkg::job_t      fifo_rd_data,
    output logic                fifo_rd,
    input  logic                take,
    output s2dc_pkg::conv_res_t res
);

    s2dc_pkg::conv_state_t           state_reg, state_next;
    logic [s2dc_pkg::VALUE_W-1:0]    mag_reg, mag_next;
    logic                            neg_reg;
    logic [s2dc_pkg::BCD_W-1:0]      bcd_reg, bcd_next;
    logic [s2dc_pkg::STEP_W-1:0]     step_reg, step_next;
    logic                            load;
    logic                            shifting;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            s2dc_pkg::CONV_IDLE:
            begin
                if (!fifo_empty)
                begin
                    state_next = s2dc_pkg::CONV_SHIFT;
                end
            end
            s2dc_pkg::CONV_SHIFT:
            begin
                if (step_reg == s2dc_pkg::STEP_W'(s2dc_pkg::STEPS-1))
                begin
                    state_next = s2dc_pkg::CONV_DONE;
                end
            end
            s2dc_pkg::CONV_DONE:
            begin
                if (take)
                begin
                    state_next = s2dc_pkg::CONV_IDLE;
                end
            end
            default:
            begin
                state_next = s2dc_pkg::CONV_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        load     = 1'b0;
        shifting = 1'b0;
        unique case (state_reg)
            s2dc_pkg::CONV_IDLE:  load     = !fifo_empty;
            s2dc_pkg::CONV_SHIFT: shifting = 1'b1;
            s2dc_pkg::CONV_DONE:  ;
            default:              ;
        endcase
    end

    assign fifo_rd   = load;
    assign res.valid = state_reg == s2dc_pkg::CONV_DONE;
    assign res.neg   = neg_reg;
    assign res.bcd   = bcd_reg;

    // four dependent adjust-and-shift steps, magnitude bits msb first
    always_comb
    begin
        bcd_next = bcd_reg;
        for (int i = 0; i < s2dc_pkg::BITS_PER_STEP; i++)
        begin
            bcd_next = s2dc_pkg::dabble_bit(bcd_next, mag_reg[s2dc_pkg::VALUE_W-1-i]);
        end
        mag_next  = {mag_reg[s2dc_pkg::VALUE_W-1-s2dc_pkg::BITS_PER_STEP:0],
                     {s2dc_pkg::BITS_PER_STEP{1'b0}}};
        step_next = step_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= s2dc_pkg::CONV_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
            begin
                step_reg <= '0;
            end
            else if (shifting)
            begin
                step_reg <= step_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mag_reg <= fifo_rd_data.mag;
            neg_reg <= fifo_rd_data.neg;
            bcd_reg <= '0;
        end
        else if (shifting)
        begin
            mag_reg <= mag_next;
            bcd_reg <= bcd_next;
        end
    end

endmodule

@@ hw/rtl/s2dc_emit.sv @@
// character emitter: walks the bcd digits msb first, drops leading zeros,
// puts out an optional minus and the digits through an output register
// depends on s2dc_pkg
`timescale 1ns / 1ps

module s2dc_emit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  s2dc_pkg::conv_res_t              res,
    output logic                             take,
    output logic                             empty,
    input  logic                             pop,
    output logic [s2dc_pkg::CHAR_W-1:0]      char_code,
    output logic [s2dc_pkg::CNT_W-1:0]       chars_so_far,
    output logic                             is_last
);

    logic                              busy_reg, busy_next;
    logic                              minus_reg, minus_next;
    logic                              started_reg, started_next;
    logic [s2dc_pkg::CNT_W-1:0]        left_reg, left_next;
    logic [s2dc_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic [s2dc_pkg::BCD_W-1:0]        bcd_reg, bcd_next;
    logic                              out_valid_reg, out_valid_next;
    logic [s2dc_pkg::CHAR_W-1:0]       out_char_reg, out_char_next;
    logic [s2dc_pkg::CNT_W-1:0]        out_cnt_reg;
    logic                              out_last_reg, out_last_next;

    logic [s2dc_pkg::DIGIT_W-1:0]      top;
    logic                              can_out;
    logic                              skip;
    logic                              emit_minus;
    logic                              emit_digit;
    logic                              produce;
    logic                              advance;
    logic                              last_digit;
    logic [s2dc_pkg::CNT_W-1:0]        cnt_inc;

    assign take       = !busy_reg && res.valid;
    assign can_out    = !out_valid_reg || pop;
    assign top        = bcd_reg[s2dc_pkg::BCD_W-1 -: s2dc_pkg::DIGIT_W];
    assign last_digit = left_reg == s2dc_pkg::CNT_W'(1);
    // leading zero, but the units digit always prints
    assign skip       = busy_reg && !minus_reg && !started_reg && (top == '0) && !last_digit;
    assign emit_minus = busy_reg && minus_reg && can_out;
    assign emit_digit = busy_reg && !minus_reg && !skip && can_out;
    assign produce    = emit_minus || emit_digit;
    assign advance    = skip || emit_digit;
    assign cnt_inc    = cnt_reg + 1'b1;

    always_comb
    begin
        busy_next    = busy_reg;
        minus_next   = minus_reg;
        started_next = started_reg;
        left_next    = left_reg;
        cnt_next     = cnt_reg;
        bcd_next     = bcd_reg;
        if (take)
        begin
            busy_next    = 1'b1;
            minus_next   = res.neg;
            started_next = 1'b0;
            left_next    = s2dc_pkg::CNT_W'(s2dc_pkg::DIGITS);
            cnt_next     = '0;
            bcd_next     = res.bcd;
        end
        else
        begin
            if (emit_minus)
            begin
                minus_next = 1'b0;
            end
            if (emit_digit)
            begin
                started_next = 1'b1;
                if (last_digit)
                begin
                    busy_next = 1'b0;
                end
            end
            if (produce)
            begin
                cnt_next = cnt_inc;
            end
            if (advance)
            begin
                left_next = left_reg - 1'b1;
                bcd_next  = {bcd_reg[s2dc_pkg::BCD_W-s2dc_pkg::DIGIT_W-1:0],
                             {s2dc_pkg::DIGIT_W{1'b0}}};
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (produce)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
        out_char_next = emit_minus ? s2dc_pkg::CHAR_MINUS :
                        s2dc_pkg::CHAR_ZERO + s2dc_pkg::CHAR_W'(top);
        out_last_next = emit_digit && last_digit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            minus_reg     <= 1'b0;
            started_reg   <= 1'b0;
            left_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            minus_reg     <= minus_next;
            started_reg   <= started_next;
            left_reg      <= left_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_reg <= bcd_next;
        if (produce)
        begin
            out_char_reg <= out_char_next;
            out_cnt_reg  <= cnt_inc;
            out_last_reg <= out_last_next;
        end
    end

    assign empty        = !out_valid_reg;
    assign char_code    = out_char_reg;
    assign chars_so_far = out_cnt_reg;
    assign is_last      = out_last_reg;

endmodule
